// ===== sv/lkvc_pkg.sv =====
// Package for the LRU key/handle cache: shared constants, item and state types.
// No dependencies; every other file in sv/ except lkvc_ram refers to it by scoped names.
package lkvc_pkg;

  localparam int ENTRIES_DEF = 16;   // default number of cache slots
  localparam int CAP_W       = 5;    // capacity register width
  localparam int KEY_W       = 32;
  localparam int HND_W       = 32;
  localparam int QDEPTH      = 2;    // front-to-back queue depth
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [HND_W-1:0] handle;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE
  } back_st_t;

endpackage

// ===== sv/lkvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/lkvc_front.sv =====
// Front end: accepts request transactions, decodes the request type and
// queues them for the back end. Depends on lkvc_pkg.
module lkvc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [lkvc_pkg::KEY_W-1:0]     in_key,
  input  logic [lkvc_pkg::HND_W-1:0]     in_handle,
  output logic                           q_valid,
  output lkvc_pkg::item_t                q_item,
  input  logic                           q_pop
);

  localparam int PW = $clog2(lkvc_pkg::QDEPTH);
  localparam int FW = $clog2(lkvc_pkg::QDEPTH + 1);

  lkvc_pkg::item_t slot_r [lkvc_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FW-1:0]   fill_r;
  logic            push;
  lkvc_pkg::item_t item_in;

  assign in_ready = (fill_r != FW'(lkvc_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != '0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    item_in.op     = in_req_type ? lkvc_pkg::OP_INSERT : lkvc_pkg::OP_LOOKUP;
    item_in.key    = in_key;
    item_in.handle = in_handle;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(lkvc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(lkvc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (!push && q_pop) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/lkvc_back.sv =====
// Back end: scans the slot memories for the key, a free slot and the LRU slot, decides,
// writes back and walks the recency ranks. Depends on lkvc_pkg, lkvc_ram.
module lkvc_back #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [lkvc_pkg::CAP_W-1:0]     capacity,
  input  logic                           q_valid,
  input  lkvc_pkg::item_t                q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [lkvc_pkg::HND_W-1:0]     out_handle_out,
  output logic                           out_evicted,
  output logic [lkvc_pkg::KEY_W-1:0]     out_evicted_key,
  output logic [lkvc_pkg::HND_W-1:0]     out_evicted_handle
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int EW  = ((CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W) + 1;
  localparam int KVW = lkvc_pkg::KEY_W + lkvc_pkg::HND_W;

  lkvc_pkg::back_st_t st_r, st_nxt;
  logic [IW:0]   cnt_r, cnt_nxt;
  logic          dv_r, dv_nxt;
  logic [IW-1:0] didx_r, didx_nxt;

  lkvc_pkg::op_t              op_r;
  logic [lkvc_pkg::KEY_W-1:0] key_r;
  logic [lkvc_pkg::HND_W-1:0] hnd_r;

  logic                       match_r;
  logic [IW-1:0]              midx_r;
  logic [IW-1:0]              mrank_r;
  logic [lkvc_pkg::HND_W-1:0] mhnd_r;
  logic                       lru_found_r;
  logic [IW-1:0]              lidx_r;
  logic [IW-1:0]              lrank_r;
  logic [lkvc_pkg::KEY_W-1:0] lkey_r;
  logic [lkvc_pkg::HND_W-1:0] lhnd_r;
  logic                       free_found_r;
  logic [IW-1:0]              fidx_r;

  logic [IW-1:0] tgt_r;
  logic [IW-1:0] rref_r;
  logic          ins_mode_r;

  logic [ENTRIES-1:0] valid_r;
  logic [CW-1:0]      count_r;

  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [lkvc_pkg::HND_W-1:0] out_hnd_r;
  logic                       out_ev_r;
  logic [lkvc_pkg::KEY_W-1:0] out_evk_r;
  logic [lkvc_pkg::HND_W-1:0] out_evh_r;

  logic           kv_we, rk_we, load_out;
  logic [IW-1:0]  rd_addr;
  logic [KVW-1:0] kv_rd;
  logic [IW-1:0]  rk_rd, rk_wdata;

  logic          is_ins, ins_new, evict, need_upd, cur_valid;
  logic [IW-1:0] slot, tgt;
  logic [EW-1:0] cap_x, effcap, count_x;

  // Decision logic, valid once the scan is done
  always_comb begin
    cap_x   = EW'(capacity);
    count_x = EW'(count_r);
    if (cap_x == '0) begin
      effcap = EW'(1);
    end else if (cap_x > EW'(ENTRIES)) begin
      effcap = EW'(ENTRIES);
    end else begin
      effcap = cap_x;
    end
    is_ins    = (op_r == lkvc_pkg::OP_INSERT);
    ins_new   = is_ins && !match_r;
    evict     = ins_new && ((count_x >= effcap) || !free_found_r);
    slot      = evict ? lidx_r : fidx_r;
    need_upd  = ins_new || (match_r && !is_ins);
    tgt       = is_ins ? slot : midx_r;
    cur_valid = valid_r[didx_r];
  end

  // Rank rewrite during the update walk
  always_comb begin
    if (didx_r == tgt_r) begin
      rk_wdata = '0;
    end else if (cur_valid && (ins_mode_r || (rk_rd < rref_r))) begin
      rk_wdata = rk_rd + 1'b1;
    end else begin
      rk_wdata = rk_rd;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    dv_nxt   = 1'b0;
    didx_nxt = cnt_r[IW-1:0];
    rd_addr  = cnt_r[IW-1:0];
    q_pop    = 1'b0;
    kv_we    = 1'b0;
    rk_we    = 1'b0;
    load_out = 1'b0;
    unique case (st_r)
      lkvc_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cnt_nxt = '0;
          st_nxt  = lkvc_pkg::ST_SCAN;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        if (cnt_r < (IW+1)'(ENTRIES)) begin
          dv_nxt  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else if (!dv_r) begin
          st_nxt = lkvc_pkg::ST_DECIDE;
        end
      end
      lkvc_pkg::ST_DECIDE: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          kv_we    = ins_new;
          cnt_nxt  = '0;
          st_nxt   = need_upd ? lkvc_pkg::ST_UPDATE : lkvc_pkg::ST_IDLE;
        end
      end
      lkvc_pkg::ST_UPDATE: begin
        rk_we = dv_r;
        if (cnt_r < (IW+1)'(ENTRIES)) begin
          dv_nxt  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else if (!dv_r) begin
          st_nxt = lkvc_pkg::ST_IDLE;
        end
      end
      default: st_nxt = lkvc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= lkvc_pkg::ST_IDLE;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      dv_r  <= dv_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        if (ins_new) begin
          valid_r[slot] <= 1'b1;
          if (!evict) begin
            count_r <= count_r + 1'b1;
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    didx_r <= didx_nxt;
    if (q_pop) begin
      op_r         <= q_item.op;
      key_r        <= q_item.key;
      hnd_r        <= q_item.handle;
      match_r      <= 1'b0;
      lru_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end
    if (st_r == lkvc_pkg::ST_SCAN && dv_r) begin
      if (cur_valid && !match_r && kv_rd[KVW-1:lkvc_pkg::HND_W] == key_r) begin
        match_r <= 1'b1;
        midx_r  <= didx_r;
        mrank_r <= rk_rd;
        mhnd_r  <= kv_rd[lkvc_pkg::HND_W-1:0];
      end
      if (cur_valid && (!lru_found_r || rk_rd > lrank_r)) begin
        lru_found_r <= 1'b1;
        lidx_r      <= didx_r;
        lrank_r     <= rk_rd;
        lkey_r      <= kv_rd[KVW-1:lkvc_pkg::HND_W];
        lhnd_r      <= kv_rd[lkvc_pkg::HND_W-1:0];
      end
      if (!cur_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        fidx_r       <= didx_r;
      end
    end
    if (load_out) begin
      tgt_r      <= tgt;
      rref_r     <= mrank_r;
      ins_mode_r <= is_ins;
      out_hit_r  <= match_r;
      out_hnd_r  <= (match_r && !is_ins) ? mhnd_r : '0;
      out_ev_r   <= evict;
      out_evk_r  <= evict ? lkey_r : '0;
      out_evh_r  <= evict ? lhnd_r : '0;
    end
  end

  lkvc_ram #(.WIDTH(KVW), .DEPTH(ENTRIES)) u_kv_ram (
    .clk     (clk),
    .wr_en   (kv_we),
    .wr_addr (slot),
    .wr_data ({key_r, hnd_r}),
    .rd_addr (rd_addr),
    .rd_data (kv_rd)
  );

  lkvc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rank_ram (
    .clk     (clk),
    .wr_en   (rk_we),
    .wr_addr (didx_r),
    .wr_data (rk_wdata),
    .rd_addr (rd_addr),
    .rd_data (rk_rd)
  );

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_handle_out     = out_hnd_r;
  assign out_evicted        = out_ev_r;
  assign out_evicted_key    = out_evk_r;
  assign out_evicted_handle = out_evh_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES)) else $error("entry count above slot count");

  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r)) else $error("count disagrees with valid bits");

  a_evict_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && evict) |-> lru_found_r) else $error("eviction without a victim");

  a_insert_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && ins_new) |=> (count_r != '0)) else $error("insert left cache empty");

endmodule

// ===== sv/lru_key_value_cache_top.sv =====
// Top level of the fully associative LRU key/handle cache.
// Depends on lkvc_pkg, lkvc_front, lkvc_back (and lkvc_ram below it).
//
//  channel | direction | handshake               | payload
//  in_     | input     | in_valid / in_ready     | req_type, key, handle
//  out_    | output    | out_valid / out_ready   | hit, handle_out, evicted, evicted_key/handle
//  cfg_    | APB slave | psel, penable, pready=1 | capacity at byte address 0
//
// Each transaction takes a pop step, one pass over the key/rank memories to find
// the key, a free slot and the LRU slot (through the read pipeline), a decide step,
// then a second pass over the rank memory to rewrite the recency order (skipped on
// a lookup miss or a repeated insert).
// Reset is synchronous, active low; it empties the cache and sets capacity to 16.
// A two-entry queue lets requests land while the back end works; the result
// register holds one result, and the back end stalls in its decide step only.
module lru_key_value_cache_top #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_req_type,
  input  logic [lkvc_pkg::KEY_W-1:0] in_key,
  input  logic [lkvc_pkg::HND_W-1:0] in_handle,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [lkvc_pkg::HND_W-1:0] out_handle_out,
  output logic                       out_evicted,
  output logic [lkvc_pkg::KEY_W-1:0] out_evicted_key,
  output logic [lkvc_pkg::HND_W-1:0] out_evicted_handle,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [1:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  logic [lkvc_pkg::CAP_W-1:0] capacity_r;
  logic                       q_valid, q_pop;
  lkvc_pkg::item_t            q_item;

  // Single register: every address decodes to capacity
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {(32 - lkvc_pkg::CAP_W)'(cfg_paddr & 2'b00), capacity_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      capacity_r <= cfg_pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  lkvc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .in_handle   (in_handle),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  lkvc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .capacity           (capacity_r),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_handle_out     (out_handle_out),
    .out_evicted        (out_evicted),
    .out_evicted_key    (out_evicted_key),
    .out_evicted_handle (out_evicted_handle)
  );

endmodule

// ===== verif/tb_lru_key_value_cache_top.sv =====
// Self-checking testbench for the LRU key/handle cache top level.
// Depends on lkvc_pkg and lru_key_value_cache_top; models the cache in a scoreboard class.

class lru_scoreboard;
  // cache model state
  logic [31:0] keys [16];
  logic [31:0] hnds [16];
  bit          vld  [16];
  int unsigned rank [16];
  int unsigned count;
  int unsigned cap;
  // expected results, one packed word per transaction
  logic [97:0] exp_q[$];
  int unsigned  errors;
  int unsigned  hits, evicts, checked;

  function void reset_model();
    for (int i = 0; i < 16; i++) begin
      vld[i] = 0; rank[i] = 0; keys[i] = 0; hnds[i] = 0;
    end
    count = 0; cap = 16; errors = 0;
  endfunction

  function void set_capacity(logic [4:0] v);
    cap = v;
  endfunction

  // predict the result of one accepted request and update the model
  function void note_request(lkvc_pkg::op_t op, logic [31:0] k, logic [31:0] h);
    int idx, slot;
    bit ev, hit;
    logic [31:0] hout, ek, eh;
    int unsigned ecap, r;
    idx = -1; slot = -1; hit = 0; hout = 0; ev = 0; ek = 0; eh = 0;
    for (int i = 0; i < 16; i++)
      if (idx < 0 && vld[i] && keys[i] == k) idx = i;
    ecap = (cap < 1) ? 1 : (cap > 16 ? 16 : cap);
    if (op == lkvc_pkg::OP_LOOKUP) begin
      if (idx >= 0) begin
        r = rank[idx];
        for (int i = 0; i < 16; i++) if (vld[i] && rank[i] < r) rank[i]++;
        rank[idx] = 0; hit = 1; hout = hnds[idx];
      end
    end else if (idx >= 0) begin
      hit = 1;
    end else begin
      ev = (count + 1 > ecap);
      if (!ev) begin
        for (int i = 0; i < 16; i++) if (slot < 0 && !vld[i]) slot = i;
        if (slot < 0) ev = 1;
      end
      if (ev) begin
        ev = 0;
        for (int i = 0; i < 16; i++)
          if (vld[i] && (slot < 0 || rank[i] > rank[slot])) slot = i;
        if (slot < 0) slot = 0;
        if (vld[slot]) begin
          ev = 1; ek = keys[slot]; eh = hnds[slot]; vld[slot] = 0;
          if (count > 0) count--;
        end
      end
      for (int i = 0; i < 16; i++) if (vld[i]) rank[i]++;
      keys[slot] = k; hnds[slot] = h; vld[slot] = 1; rank[slot] = 0;
      if (count < 16) count++;
    end
    exp_q.push_back({hit, hout, ev, ek, eh});
  endfunction

  function void check_result(bit hit, logic [31:0] hout, bit ev, logic [31:0] ek,
                             logic [31:0] eh);
    logic [97:0] e;
    if (exp_q.size() == 0) begin
      $error("result with no pending transaction");
      errors++;
      return;
    end
    e = exp_q.pop_front();
    checked++;
    if (hit) hits++;
    if (ev) evicts++;
    if (e[97] !== hit) begin
      $error("hit: expected %0h actual %0h", e[97], hit); errors++;
    end
    if (e[96:65] !== hout) begin
      $error("handle_out: expected %0h actual %0h", e[96:65], hout); errors++;
    end
    if (e[64] !== ev) begin
      $error("evicted: expected %0h actual %0h", e[64], ev); errors++;
    end
    if (e[63:32] !== ek) begin
      $error("evicted_key: expected %0h actual %0h", e[63:32], ek); errors++;
    end
    if (e[31:0] !== eh) begin
      $error("evicted_handle: expected %0h actual %0h", e[31:0], eh); errors++;
    end
  endfunction
endclass

module tb_lru_key_value_cache_top;

  localparam int LIMIT = 2000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_req_type = 0;
  logic [31:0] in_key = 0;
  logic [31:0] in_handle = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        out_hit;
  logic [31:0] out_handle_out;
  logic        out_evicted;
  logic [31:0] out_evicted_key;
  logic [31:0] out_evicted_handle;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [1:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lru_key_value_cache_top dut (.*);

  always #2 clk = ~clk;

  lru_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned send_idle = 0;   // percent of cycles the sender holds off
  int unsigned recv_stall = 0;  // percent of cycles the receiver stalls
  logic [31:0] key_pool [8];    // small key set so lookups hit and inserts repeat

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // handshake signals are stable between edges: a transaction seen here is
  // accepted at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_hit, out_handle_out, out_evicted, out_evicted_key,
                      out_evicted_handle);
  end

  // one request transaction, with an optional random hold-off before it
  task automatic send(lkvc_pkg::op_t op, logic [31:0] k, logic [31:0] h);
    bit acc;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_req_type <= op; in_key <= k; in_handle <= h;
    acc = 0;
    while (!acc) begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end
    sb.note_request(op, k, h);
  endtask

  // APB write of the capacity register; only called with the cache idle
  task automatic write_capacity(logic [4:0] v);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= 0;
    cfg_pwdata <= {27'($urandom), v};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    sb.set_capacity(v);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // mostly pool keys, sometimes fully random ones
  function automatic logic [31:0] pick_key();
    if ($urandom_range(9) < 8) return key_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send(lkvc_pkg::op_t'($urandom_range(1)), pick_key(), $urandom);
  endtask

  initial begin
    sb.reset_model();
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes of key and handle, hits, repeated insert, eviction
    send(lkvc_pkg::OP_LOOKUP, 32'h0, 32'h0);
    send(lkvc_pkg::OP_INSERT, 32'h0, 32'hFFFF_FFFF);
    send(lkvc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0);
    send(lkvc_pkg::OP_LOOKUP, 32'h0, 32'h1234_5678);
    send(lkvc_pkg::OP_INSERT, 32'h0, 32'hDEAD_BEEF);     // present key: no change
    send(lkvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send(lkvc_pkg::OP_LOOKUP, 32'hAAAA_5555, 32'h0);     // miss
    for (int i = 0; i < 17; i++)
      send(lkvc_pkg::OP_INSERT, 32'h100 + i, 32'h5555_AAAA ^ i);
    drain();
    // capacity one, then zero which acts as one, and above the slot count
    write_capacity(5'd1);
    send(lkvc_pkg::OP_INSERT, 32'h1, 32'h11);
    send(lkvc_pkg::OP_INSERT, 32'h2, 32'h22);
    drain();
    write_capacity(5'd0);
    send(lkvc_pkg::OP_INSERT, 32'h3, 32'h33);
    send(lkvc_pkg::OP_LOOKUP, 32'h3, 32'h0);
    drain();
    write_capacity(5'd31);
    random_phase(20);
    drain();

    // random phases across idling patterns and capacities
    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 45; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 45; end
        default: begin send_idle = 38; recv_stall = 38; end
      endcase
      write_capacity(p == 0 ? 5'd16 : p == 1 ? 5'd1 : 5'($urandom_range(1, 16)));
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      random_phase(100);
      drain();
    end

    send_idle = 0; recv_stall = 0;
    drain();
    $display("Checked %0d results: %0d hits, %0d evictions, capacities 0 to 31.",
             sb.checked, sb.hits, sb.evicts);
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
